@@ hdl/mp2d_pkg.sv @@
// Shared constants and types for the 2-D max pooling unit.
package mp2d_pkg;

   // Default sizing of the block.
   localparam int DEF_MAX_POOL    = 8;
   localparam int DEF_MAX_WIDTH   = 1024;
   localparam int DEF_SAMPLE_BITS = 16;

   // Fixed limits that come from the register and result field widths.
   localparam int MAX_HEIGHT  = 1024;
   localparam int MAX_STRIDE  = 8;
   localparam int IDX_W       = 10;
   localparam int HGT_W       = 11;
   localparam int CSR_ADDR_W  = 4;
   localparam int CSR_DATA_W  = 32;

   // Register indexes on the configuration port.
   localparam logic [1:0] REG_POOL_SIZE    = 2'd0;
   localparam logic [1:0] REG_POOL_STRIDE  = 2'd1;
   localparam logic [1:0] REG_FRAME_WIDTH  = 2'd2;
   localparam logic [1:0] REG_FRAME_HEIGHT = 2'd3;

   // Register values after reset.
   localparam logic [3:0]  RST_POOL_SIZE    = 4'd2;
   localparam logic [3:0]  RST_POOL_STRIDE  = 4'd2;
   localparam logic [10:0] RST_FRAME_WIDTH  = 11'd1024;
   localparam logic [10:0] RST_FRAME_HEIGHT = 11'd1024;

   // Control bundle that drives one cell of the row maximum chain.
   typedef struct packed {
      logic shift;
      logic use_tap;
      logic first;
   } cell_ctl_type;

endpackage

@@ hdl/mp2d_if.sv @@
// Stream interfaces for the pixel input and the pooled result output.
interface mp2d_req_if #(
   parameter int SAMPLE_BITS = mp2d_pkg::DEF_SAMPLE_BITS
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;
   logic                          plane_start;

   modport source (output valid, output sample, output plane_start, input ready);
   modport sink   (input valid, input sample, input plane_start, output ready);
endinterface

interface mp2d_rsp_if #(
   parameter int SAMPLE_BITS = mp2d_pkg::DEF_SAMPLE_BITS
);
   logic                               valid;
   logic                               ready;
   logic signed [SAMPLE_BITS-1:0]      pooled_max;
   logic [mp2d_pkg::IDX_W-1:0]         out_row;
   logic [mp2d_pkg::IDX_W-1:0]         out_col;
   logic                               last_of_plane;

   modport source (output valid, output pooled_max, output out_row, output out_col,
                   output last_of_plane, input ready);
   modport sink   (input valid, input pooled_max, input out_row, input out_col,
                   input last_of_plane, output ready);
endinterface

@@ hdl/mp2d_ram.sv @@
// Generic single write port, single registered read port RAM.
module mp2d_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/mp2d_cell.sv @@
// One cell of the horizontal maximum chain: holds one past sample of the row.
module mp2d_cell #(
   parameter int SAMPLE_BITS = mp2d_pkg::DEF_SAMPLE_BITS
) (
   input  logic                          clock,
   input  mp2d_pkg::cell_ctl_type        ctl,
   input  logic signed [SAMPLE_BITS-1:0] tap_in,
   input  logic signed [SAMPLE_BITS-1:0] max_in,
   output logic signed [SAMPLE_BITS-1:0] tap_out,
   output logic signed [SAMPLE_BITS-1:0] max_out
);

   logic signed [SAMPLE_BITS-1:0] tap_ff;

   // The sample moves one cell on with every accepted transaction.
   always_ff @(posedge clock) begin
      if (ctl.shift) begin
         tap_ff <= tap_in;
      end
   end

   assign tap_out = tap_ff;

   // Fold this cell's tap into the running maximum when it lies inside the window.
   always_comb begin
      if (ctl.first) begin
         max_out = tap_in;
      end else if (ctl.use_tap && (tap_in > max_in)) begin
         max_out = tap_in;
      end else begin
         max_out = max_in;
      end
   end

endmodule

@@ hdl/max_pool_2d_forward_unit.sv @@
// Max pooling top level: a pixel is taken while the sequencer is idle; a window that
// completes with that pixel then has its column of row maxima read from the line
// store (one RAM read port, one row per cycle), the compare is finished and the result
// is handed to the output register; the hand-over waits while an earlier result still
// sits there with rsp ready low. No new pixel is taken until that hand-over is done.
// A chain of MAX_POOL cells forms the maximum over the last pool_size samples of the
// row, which is what the line store keeps for each pixel.
module max_pool_2d_forward_unit #(
   parameter int MAX_POOL    = mp2d_pkg::DEF_MAX_POOL,
   parameter int MAX_WIDTH   = mp2d_pkg::DEF_MAX_WIDTH,
   parameter int SAMPLE_BITS = mp2d_pkg::DEF_SAMPLE_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   mp2d_req_if.sink                            req_ch,
   mp2d_rsp_if.source                          rsp_ch,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [mp2d_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [mp2d_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [mp2d_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready
);

   localparam int SLOT_W = (MAX_POOL > 1) ? $clog2(MAX_POOL) : 1;
   localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int WID_W  = $clog2(MAX_WIDTH + 1);
   localparam int NC_W   = WID_W + 1;
   localparam int KW     = $clog2(MAX_POOL + 1);
   localparam int DEPTH  = MAX_POOL * MAX_WIDTH;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int NR_W   = mp2d_pkg::HGT_W + 1;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_READ  = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;
   localparam logic [1:0] ST_DONE  = 2'd3;

   // Configuration registers.
   logic [3:0]  pool_size_ff, pool_stride_ff;
   logic [10:0] frame_width_ff, frame_height_ff;
   logic        csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_size_ff    <= mp2d_pkg::RST_POOL_SIZE;
         pool_stride_ff  <= mp2d_pkg::RST_POOL_STRIDE;
         frame_width_ff  <= mp2d_pkg::RST_FRAME_WIDTH;
         frame_height_ff <= mp2d_pkg::RST_FRAME_HEIGHT;
      end else if (csr_wr) begin
         case (paddr[3:2])
            mp2d_pkg::REG_POOL_SIZE:    pool_size_ff    <= pwdata[3:0];
            mp2d_pkg::REG_POOL_STRIDE:  pool_stride_ff  <= pwdata[3:0];
            mp2d_pkg::REG_FRAME_WIDTH:  frame_width_ff  <= pwdata[10:0];
            mp2d_pkg::REG_FRAME_HEIGHT: frame_height_ff <= pwdata[10:0];
            default: ;
         endcase
      end
   end

   // Register read back.
   always_comb begin
      case (paddr[3:2])
         mp2d_pkg::REG_POOL_SIZE:    prdata = {28'd0, pool_size_ff};
         mp2d_pkg::REG_POOL_STRIDE:  prdata = {28'd0, pool_stride_ff};
         mp2d_pkg::REG_FRAME_WIDTH:  prdata = {21'd0, frame_width_ff};
         mp2d_pkg::REG_FRAME_HEIGHT: prdata = {21'd0, frame_height_ff};
         default:                    prdata = '0;
      endcase
   end

   // Effective settings: zero reads as one, oversize values saturate.
   logic [KW-1:0]                k_eff;
   logic [3:0]                   s_eff;
   logic [WID_W-1:0]             w_eff;
   logic [mp2d_pkg::HGT_W-1:0]   h_eff;

   always_comb begin
      if (pool_size_ff == 4'd0) begin
         k_eff = KW'(1);
      end else if (32'(pool_size_ff) > 32'(MAX_POOL)) begin
         k_eff = KW'(MAX_POOL);
      end else begin
         k_eff = KW'(pool_size_ff);
      end
      if (pool_stride_ff == 4'd0) begin
         s_eff = 4'd1;
      end else if (32'(pool_stride_ff) > 32'(mp2d_pkg::MAX_STRIDE)) begin
         s_eff = 4'(mp2d_pkg::MAX_STRIDE);
      end else begin
         s_eff = pool_stride_ff;
      end
      if (frame_width_ff == 11'd0) begin
         w_eff = WID_W'(1);
      end else if (32'(frame_width_ff) > 32'(MAX_WIDTH)) begin
         w_eff = WID_W'(MAX_WIDTH);
      end else begin
         w_eff = WID_W'(frame_width_ff);
      end
      if (frame_height_ff == 11'd0) begin
         h_eff = mp2d_pkg::HGT_W'(1);
      end else if (32'(frame_height_ff) > 32'(mp2d_pkg::MAX_HEIGHT)) begin
         h_eff = mp2d_pkg::HGT_W'(mp2d_pkg::MAX_HEIGHT);
      end else begin
         h_eff = frame_height_ff;
      end
   end

   // Sequencer and position state.
   logic [1:0]                  state_ff, state_in;
   logic [COL_W-1:0]            col_ff, col_in;
   logic [mp2d_pkg::IDX_W-1:0]  row_ff, row_in;
   logic [SLOT_W-1:0]           slot_ff, slot_in;
   logic [NC_W-1:0]             ncol_ff, ncol_in;
   logic [NR_W-1:0]             nrow_ff, nrow_in;
   logic [mp2d_pkg::IDX_W-1:0]  wo_ff, wo_in, ho_ff, ho_in;

   logic                        accept;
   logic                        restart, row_start, hit_col, hit_row, fits, emit;
   logic                        col_last, row_last, end_col, end_row;
   logic [COL_W-1:0]            c_cur;
   logic [mp2d_pkg::IDX_W-1:0]  r_cur;
   logic [SLOT_W-1:0]           slot_cur;
   logic [NC_W-1:0]             ncol_cur;
   logic [NR_W-1:0]             nrow_cur;
   logic [mp2d_pkg::IDX_W-1:0]  wo_cur, ho_cur;
   logic [31:0]                 first_slot;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;

   // Position of the pixel in this transaction and the window grid test.
   always_comb begin
      restart   = req_ch.plane_start || (32'(row_ff) >= 32'(h_eff))
                  || (32'(col_ff) >= 32'(w_eff));
      c_cur     = restart ? '0 : col_ff;
      r_cur     = restart ? '0 : row_ff;
      slot_cur  = restart ? '0 : slot_ff;
      row_start = (c_cur == '0) && (r_cur == '0);
      ncol_cur  = (c_cur == '0) ? NC_W'(32'(k_eff) - 32'd1) : ncol_ff;
      wo_cur    = (c_cur == '0) ? '0 : wo_ff;
      nrow_cur  = row_start ? NR_W'(32'(k_eff) - 32'd1) : nrow_ff;
      ho_cur    = row_start ? '0 : ho_ff;
      hit_col   = (32'(c_cur) == 32'(ncol_cur));
      hit_row   = (32'(r_cur) == 32'(nrow_cur));
      fits      = (32'(k_eff) <= 32'(w_eff)) && (32'(k_eff) <= 32'(h_eff));
      emit      = hit_col && hit_row && fits;
      col_last  = (32'(ncol_cur) + 32'(s_eff)) >= 32'(w_eff);
      row_last  = (32'(nrow_cur) + 32'(s_eff)) >= 32'(h_eff);
      end_col   = (32'(c_cur) + 32'd1) >= 32'(w_eff);
      end_row   = (32'(r_cur) + 32'd1) >= 32'(h_eff);

      // Line store row of the top of the window, modulo MAX_POOL.
      first_slot = 32'(slot_cur) + 32'(MAX_POOL) - (32'(k_eff) - 32'd1);
      if (first_slot >= 32'(MAX_POOL)) begin
         first_slot = first_slot - 32'(MAX_POOL);
      end
   end

   // Next position after this pixel.
   always_comb begin
      col_in  = end_col ? '0 : COL_W'(32'(c_cur) + 32'd1);
      row_in  = r_cur;
      slot_in = slot_cur;
      if (end_col) begin
         row_in = end_row ? '0 : mp2d_pkg::IDX_W'(32'(r_cur) + 32'd1);
         if (end_row || (32'(slot_cur) == 32'(MAX_POOL - 1))) begin
            slot_in = '0;
         end else begin
            slot_in = SLOT_W'(32'(slot_cur) + 32'd1);
         end
      end
      ncol_in = hit_col ? NC_W'(32'(ncol_cur) + 32'(s_eff)) : ncol_cur;
      wo_in   = hit_col ? mp2d_pkg::IDX_W'(32'(wo_cur) + 32'd1) : wo_cur;
      nrow_in = (end_col && hit_row) ? NR_W'(32'(nrow_cur) + 32'(s_eff)) : nrow_cur;
      ho_in   = (end_col && hit_row) ? mp2d_pkg::IDX_W'(32'(ho_cur) + 32'd1) : ho_cur;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         slot_ff <= '0;
         ncol_ff <= '0;
         nrow_ff <= '0;
         wo_ff   <= '0;
         ho_ff   <= '0;
      end else if (accept) begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         slot_ff <= slot_in;
         ncol_ff <= ncol_in;
         nrow_ff <= nrow_in;
         wo_ff   <= wo_in;
         ho_ff   <= ho_in;
      end
   end

   // Chain of cells forming the maximum over the last pool_size samples of the row.
   logic signed [SAMPLE_BITS-1:0] tap_w [MAX_POOL];
   logic signed [SAMPLE_BITS-1:0] max_w [MAX_POOL];

   for (genvar i = 0; i < MAX_POOL; i++) begin : g_cell
      mp2d_pkg::cell_ctl_type        ctl;
      logic signed [SAMPLE_BITS-1:0] tap_src, max_src;

      assign ctl.shift   = accept;
      assign ctl.use_tap = (32'(i) < 32'(k_eff));
      assign ctl.first   = (i == 0);
      if (i == 0) begin : g_head
         assign tap_src = req_ch.sample;
         assign max_src = req_ch.sample;
      end else begin : g_body
         assign tap_src = tap_w[i-1];
         assign max_src = max_w[i-1];
      end

      mp2d_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell (
         .clock   (clock),
         .ctl     (ctl),
         .tap_in  (tap_src),
         .max_in  (max_src),
         .tap_out (tap_w[i]),
         .max_out (max_w[i])
      );
   end

   // Line store of row maxima, MAX_POOL rows of MAX_WIDTH columns.
   logic [ADDR_W-1:0]      wr_addr, rd_addr;
   logic                   rd_en;
   logic [SAMPLE_BITS-1:0] rd_data;
   logic [SLOT_W-1:0]      rd_slot_ff, rd_slot_in;
   logic [COL_W-1:0]       rd_col_ff;
   logic [KW-1:0]          rd_left_ff;
   logic                   rd_v_ff, acc_has_ff;
   logic signed [SAMPLE_BITS-1:0] best_ff;
   logic [mp2d_pkg::IDX_W-1:0]    ho_hold_ff, wo_hold_ff;
   logic                          last_hold_ff;

   assign wr_addr = ADDR_W'(32'(slot_cur) * 32'(MAX_WIDTH) + 32'(c_cur));
   assign rd_addr = ADDR_W'(32'(rd_slot_ff) * 32'(MAX_WIDTH) + 32'(rd_col_ff));
   assign rd_en   = (state_ff == ST_READ);
   assign rd_slot_in = (32'(rd_slot_ff) == 32'(MAX_POOL - 1)) ? '0
                       : SLOT_W'(32'(rd_slot_ff) + 32'd1);

   mp2d_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(DEPTH)) u_line_store (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (wr_addr),
      .wr_data (max_w[MAX_POOL-1]),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Sequencer: take a pixel, read the window column, then hand over the result.
   logic rsp_valid_ff;
   logic rsp_free;

   assign rsp_free = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (accept && emit) state_in = ST_READ;
         ST_READ:  if (rd_left_ff == KW'(1)) state_in = ST_DRAIN;
         ST_DRAIN: state_in = ST_DONE;
         ST_DONE:  if (rsp_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         rd_v_ff    <= 1'b0;
         acc_has_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rd_v_ff  <= rd_en;
         if (accept) begin
            acc_has_ff <= 1'b0;
         end else if (rd_v_ff) begin
            acc_has_ff <= 1'b1;
         end
      end
   end

   // Read addresses and the running window maximum.
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_slot_ff   <= SLOT_W'(first_slot);
         rd_col_ff    <= c_cur;
         rd_left_ff   <= k_eff;
         ho_hold_ff   <= ho_cur;
         wo_hold_ff   <= wo_cur;
         last_hold_ff <= col_last && row_last;
      end else if (rd_en) begin
         rd_slot_ff <= rd_slot_in;
         rd_left_ff <= KW'(32'(rd_left_ff) - 32'd1);
      end
      if (rd_v_ff && (!acc_has_ff || ($signed(rd_data) > best_ff))) begin
         best_ff <= $signed(rd_data);
      end
   end

   // Output register.
   logic signed [SAMPLE_BITS-1:0] pooled_ff;
   logic [mp2d_pkg::IDX_W-1:0]    out_row_ff, out_col_ff;
   logic                          last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((state_ff == ST_DONE) && rsp_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == ST_DONE) && rsp_free) begin
         pooled_ff  <= best_ff;
         out_row_ff <= ho_hold_ff;
         out_col_ff <= wo_hold_ff;
         last_ff    <= last_hold_ff;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.pooled_max    = pooled_ff;
   assign rsp_ch.out_row       = out_row_ff;
   assign rsp_ch.out_col       = out_col_ff;
   assign rsp_ch.last_of_plane = last_ff;

`ifndef ASSERT_OFF
   // A new result only appears at the end of a window read.
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_DONE)
      else $error("result raised outside the hand-over step");

   // No pixel is taken while a window is being read.
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_ch.ready)
      else $error("pixel accepted during window read");

   // The read phase never runs past the window height.
   a_read_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> (rd_left_ff != '0) && (32'(rd_left_ff) <= 32'(MAX_POOL)))
      else $error("window read count out of range");
`endif

endmodule

@@ verif/max_pool_2d_forward_unit_checker.sv @@
// Transaction monitor, pooled-result predictor and comparator for the max pooling unit.
module max_pool_2d_forward_unit_checker
   import mp2d_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   mp2d_req_if                   req_ch,
   mp2d_rsp_if                   rsp_ch,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   input  logic                  pready,
   output int                    mismatches,
   output int                    windows_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic signed [15:0] pooled_max;
      logic [IDX_W-1:0]   out_row;
      logic [IDX_W-1:0]   out_col;
      logic               last_of_plane;
   } pooled_type;

   pooled_type         pooled_queue[$];
   logic [3:0]         pool_size_reg, pool_stride_reg;
   logic [10:0]        width_reg, height_reg;
   logic signed [15:0] row_buffer[DEF_MAX_POOL][DEF_MAX_WIDTH];
   int                 cur_row, cur_col;

   function automatic int clamp_reg(int v, int hi);
      if (v == 0) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   // Store one pixel and return the window that it completes, if any.
   function automatic bit pool_pixel(logic signed [15:0] pixel, logic start,
                                     output pooled_type res);
      int k, s, w, h, top, left, ho, wo;
      logic signed [15:0] best;
      k = clamp_reg(pool_size_reg, DEF_MAX_POOL);
      s = clamp_reg(pool_stride_reg, MAX_STRIDE);
      w = clamp_reg(width_reg, DEF_MAX_WIDTH);
      h = clamp_reg(height_reg, MAX_HEIGHT);
      pool_pixel = 0;
      res = '{default: '0};
      if (start || cur_row >= h || cur_col >= w) begin
         cur_row = 0;
         cur_col = 0;
      end
      row_buffer[cur_row % DEF_MAX_POOL][cur_col] = pixel;
      top = cur_row + 1 - k;
      left = cur_col + 1 - k;
      if (k <= w && k <= h && top >= 0 && left >= 0 && top % s == 0 && left % s == 0) begin
         best = row_buffer[top % DEF_MAX_POOL][left];
         for (int i = 0; i < k; i++) begin
            for (int j = 0; j < k; j++) begin
               if (row_buffer[(top + i) % DEF_MAX_POOL][left + j] > best)
                  best = row_buffer[(top + i) % DEF_MAX_POOL][left + j];
            end
         end
         ho = top / s;
         wo = left / s;
         res.pooled_max = best;
         res.out_row = ho[IDX_W-1:0];
         res.out_col = wo[IDX_W-1:0];
         res.last_of_plane = (ho == (h - k) / s) && (wo == (w - k) / s);
         pool_pixel = 1;
      end
      cur_col++;
      if (cur_col >= w) begin
         cur_col = 0;
         cur_row++;
         if (cur_row >= h) cur_row = 0;
      end
   endfunction

   // Track register writes, predict on each input transaction and compare outputs.
   always @(posedge clock) begin
      pooled_type res, exp_res;
      if (reset) begin
         pool_size_reg = RST_POOL_SIZE;
         pool_stride_reg = RST_POOL_STRIDE;
         width_reg = RST_FRAME_WIDTH;
         height_reg = RST_FRAME_HEIGHT;
         cur_row = 0;
         cur_col = 0;
         pooled_queue.delete();
         foreach (row_buffer[i, j]) row_buffer[i][j] = '0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[3:2])
               REG_POOL_SIZE:    pool_size_reg = pwdata[3:0];
               REG_POOL_STRIDE:  pool_stride_reg = pwdata[3:0];
               REG_FRAME_WIDTH:  width_reg = pwdata[10:0];
               REG_FRAME_HEIGHT: height_reg = pwdata[10:0];
            endcase
         end
         if (req_ch.valid && req_ch.ready) begin
            if (pool_pixel(req_ch.sample, req_ch.plane_start, res)) pooled_queue.push_back(res);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pooled_queue.size() == 0) begin
               $error("unexpected pooled result row %0d col %0d", rsp_ch.out_row,
                      rsp_ch.out_col);
               mismatches++;
            end else begin
               exp_res = pooled_queue.pop_front();
               if (rsp_ch.pooled_max !== exp_res.pooled_max) begin
                  $error("pooled_max: expected %0d, actual %0d", exp_res.pooled_max,
                         rsp_ch.pooled_max);
                  mismatches++;
               end
               if (rsp_ch.out_row !== exp_res.out_row) begin
                  $error("out_row: expected %0d, actual %0d", exp_res.out_row,
                         rsp_ch.out_row);
                  mismatches++;
               end
               if (rsp_ch.out_col !== exp_res.out_col) begin
                  $error("out_col: expected %0d, actual %0d", exp_res.out_col,
                         rsp_ch.out_col);
                  mismatches++;
               end
               if (rsp_ch.last_of_plane !== exp_res.last_of_plane) begin
                  $error("last_of_plane: expected %0d, actual %0d", exp_res.last_of_plane,
                         rsp_ch.last_of_plane);
                  mismatches++;
               end
            end
         end
      end
      windows_pending <= pooled_queue.size();
   end

   initial mismatches = 0;

endmodule

@@ verif/max_pool_2d_forward_unit_tb.sv @@
// Stimulus, register programming and verdict for the max pooling unit.
module max_pool_2d_forward_unit_tb;
   import mp2d_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DRAIN_CYCLES = 24;
   localparam int CYCLE_LIMIT  = 600000;

   logic                  clock = 0;
   logic                  reset;
   logic                  psel, penable, pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;
   int                    mismatches, windows_pending;
   int                    burst_left, pixels_sent, cycle_count;

   mp2d_req_if req_ch();
   mp2d_rsp_if rsp_ch();

   max_pool_2d_forward_unit i_dut (
      .clock, .reset, .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source),
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   max_pool_2d_forward_unit_checker i_checker (
      .clock, .reset, .req_ch, .rsp_ch, .psel, .penable, .pwrite, .paddr, .pwdata,
      .pready, .mismatches, .windows_pending
   );

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("max_pool_2d_forward_unit_tb failed");
         $finish;
      end
   end

   // Result backpressure: the pattern steps through four modes in turn, with full-rate stretches.
   always @(posedge clock) begin
      case ((cycle_count / 64) % 4)
         0:       rsp_ch.ready <= 1'b1;
         1:       rsp_ch.ready <= $urandom_range(0, 1);
         2:       rsp_ch.ready <= ($urandom_range(0, 5) == 0);
         default: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
      endcase
   end

   // Drop valid and wait until every predicted window has been returned.
   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      do @(negedge clock); while (windows_pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // One register write: setup phase, access phase, then idle.
   task automatic csr_write(logic [1:0] idx, logic [CSR_DATA_W-1:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_geometry(int k, int s, int w, int h);
      wait_idle();
      csr_write(REG_POOL_SIZE, k);
      csr_write(REG_POOL_STRIDE, s);
      csr_write(REG_FRAME_WIDTH, w);
      csr_write(REG_FRAME_HEIGHT, h);
   endtask

   // Send one pixel transaction; the sender idles between bursts of random length.
   task automatic send_pixel(logic signed [15:0] pixel, logic start);
      logic took;
      if (burst_left == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 12);
      end
      burst_left--;
      req_ch.valid <= 1'b1;
      req_ch.sample <= pixel;
      req_ch.plane_start <= start;
      do begin
         @(negedge clock);
         took = req_ch.ready;
         @(posedge clock);
      end while (!took);
      pixels_sent++;
   endtask

   function automatic logic signed [15:0] random_pixel();
      case ($urandom_range(0, 9))
         0:       return 16'sh7fff;
         1:       return 16'sh8000;
         2:       return -16'($urandom_range(0, 3));
         default: return 16'($urandom);
      endcase
   endfunction

   // Feed a number of raster pixels, with the first flagged as a plane start or not.
   task automatic send_pixels(int count, bit first_start);
      for (int n = 0; n < count; n++) send_pixel(random_pixel(), first_start && n == 0);
   endtask

   initial begin
      int k, s, w, h, planes, npix;
      reset = 1'b1;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      req_ch.valid = 1'b0;
      req_ch.sample = '0;
      req_ch.plane_start = 1'b0;
      rsp_ch.ready = 1'b1;
      cycle_count = 0;
      burst_left = 0;
      pixels_sent = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: 2x2 windows over a 4x2 plane with the sample extremes.
      set_geometry(2, 2, 4, 2);
      send_pixel(16'sh8000, 1'b1);
      send_pixel(16'sh7fff, 1'b0);
      send_pixel(16'sh8000, 1'b0);
      send_pixel(16'sh8000, 1'b0);
      send_pixel(16'sh0000, 1'b0);
      send_pixel(-16'sd1, 1'b0);
      send_pixel(16'sh8000, 1'b0);
      send_pixel(16'sh8001, 1'b0);
      // Zero registers act as one; the plane wraps without a start flag.
      set_geometry(0, 0, 0, 0);
      send_pixel(16'sh7fff, 1'b1);
      send_pixel(16'sh8000, 1'b0);
      // Window wider than the plane never completes.
      set_geometry(8, 1, 5, 9);
      send_pixels(4, 1);
      // Oversize registers are limited to their maximum.
      set_geometry(15, 15, 2047, 2047);
      send_pixels(3, 1);
      // Height shrunk under the current row restarts the plane.
      set_geometry(1, 1, 4, 4);
      send_pixels(9, 1);
      wait_idle();
      csr_write(REG_FRAME_HEIGHT, 2);
      send_pixels(3, 0);

      // Random geometries with mostly well-formed planes.
      while (pixels_sent < 900) begin
         k = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8);
         s = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8);
         w = ($urandom_range(0, 12) == 0) ? 0 : $urandom_range(1, 24);
         h = ($urandom_range(0, 12) == 0) ? 0 : $urandom_range(1, 12);
         set_geometry(k, s, w, h);
         planes = $urandom_range(1, 4);
         npix = ((w == 0) ? 1 : w) * ((h == 0) ? 1 : h);
         for (int p = 0; p < planes && pixels_sent < 900; p++) begin
            if ($urandom_range(0, 9) == 0) begin
               // A plane cut short; the next one must be flagged.
               send_pixels($urandom_range(1, npix), 1);
               send_pixels(npix, 1);
            end else begin
               send_pixels(npix, p == 0 || $urandom_range(0, 5) != 0);
            end
            if ($urandom_range(0, 7) == 0) wait_idle();
         end
      end

      wait_idle();
      if (mismatches == 0) begin
         $display("max_pool_2d_forward_unit_tb passed");
      end else begin
         $display("max_pool_2d_forward_unit_tb failed");
      end
      $finish;
   end

endmodule
